// File: design/rpcs_pkg.sv
// Shared constants and types for the rotary position cosine/sine generator.
package rpcs_pkg;

   localparam int MAX_PAIRS_DEF = 64;
   localparam int POS_BITS_DEF  = 20;
   localparam int FREQ_BITS_DEF = 48;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int PAIRS_W    = 7;
   localparam int AMP_W      = 16;
   localparam int IDX_W      = 6;
   localparam int OUT_W      = 18;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACTIVE_PAIRS = 2'd0,
      CSR_AMP_SCALE    = 2'd1
   } csr_index_type;

   typedef enum logic {
      ACT_LOAD    = 1'b0,
      ACT_COMPUTE = 1'b1
   } action_type;

   localparam logic [PAIRS_W-1:0] ACTIVE_PAIRS_RST = 7'd64;
   localparam logic [AMP_W-1:0]   AMP_SCALE_RST    = 16'd16384;

   // Q30 polynomial for sin(pi/2 * x)
   localparam logic [30:0] Q30_ONE = 31'h4000_0000;
   localparam logic [30:0] C1 = 31'd1686629713;
   localparam logic [30:0] C3 = 31'd693598675;
   localparam logic [30:0] C5 = 31'd85569306;
   localparam logic [30:0] C7 = 31'd5026995;
   localparam logic [30:0] C9 = 31'd172273;

   localparam logic [18:0] POS_SAT = 19'd131071;
   localparam logic [18:0] NEG_SAT = 19'd131072;

   // carries one pair through the polynomial stages
   typedef struct packed {
      logic        valid;
      logic        last;
      logic [5:0]  pair;
      logic [1:0]  quad;
      logic [30:0] xs;
      logic [30:0] xc;
      logic [30:0] x2s;
      logic [30:0] x2c;
      logic [30:0] ts;
      logic [30:0] tc;
   } poly_type;

   // one Horner step: c - (x2 * t) >> 30
   function automatic logic [30:0] horner_step(input logic [30:0] x2,
                                                input logic [30:0] t,
                                                input logic [30:0] c);
      logic [61:0] prod;
      prod = 62'(x2) * 62'(t);
      return c - prod[60:30];
   endfunction

   function automatic logic [30:0] q30_mul(input logic [30:0] a,
                                           input logic [30:0] b);
      logic [61:0] prod;
      prod = 62'(a) * 62'(b);
      return prod[60:30];
   endfunction

endpackage

// File: design/rotary_position_cos_sin_generator_top.sv
// Rotary position cosine/sine generator: frequency table, phase and polynomial pipeline.
//
// Usage
//   req_* : one word per item. action = load writes entry_freq into table
//           entry entry_index and gives no result. action = compute takes
//           position and gives one rsp_* word per active pair, pair 0 first,
//           with rsp_last on the final pair.
//   rsp_* : pair_index, cosine, sine (signed, 32768 = 1.0, saturated), last.
//   csr_* : write port; index 0 active_pairs, index 1 amp_scale. Write only
//           while the block is idle.
// Throughput
//   A load does not raise req_stall. A compute issues one table read per cycle
//   while rsp_stall does not hold the pipeline, and req_stall stays high until
//   the last read of the run has issued, so no new word is taken during a run.
//   The rate is set by the single read port of the frequency table. req_stall
//   is high while a run is issuing and while a result word waits on rsp_stall.
// Reset
//   Synchronous, active high. Clears control state and valid bits and sets
//   active_pairs to 64 and amp_scale to 1.0. Table contents are undefined
//   until loaded.
// Back-pressure
//   While rsp_valid is high and rsp_stall is high the whole pipeline,
//   table read included, freezes, the output word holds and req_stall is high.
module rotary_position_cos_sin_generator_top #(
   parameter int MAX_PAIRS = rpcs_pkg::MAX_PAIRS_DEF,
   parameter int POS_BITS  = rpcs_pkg::POS_BITS_DEF,
   parameter int FREQ_BITS = rpcs_pkg::FREQ_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_action,
   input  logic [POS_BITS-1:0]            req_position,
   input  logic [rpcs_pkg::IDX_W-1:0]     req_entry_index,
   input  logic [FREQ_BITS-1:0]           req_entry_freq,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [rpcs_pkg::IDX_W-1:0]     rsp_pair_index,
   output logic signed [rpcs_pkg::OUT_W-1:0] rsp_cosine,
   output logic signed [rpcs_pkg::OUT_W-1:0] rsp_sine,
   output logic                           rsp_last,
   input  logic                           csr_we,
   input  logic [rpcs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rpcs_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rpcs_pkg::*;

   localparam int AW   = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int CW   = $clog2(MAX_PAIRS + 1);
   localparam int LO_W = (FREQ_BITS + 1) / 2;
   localparam int HI_W = FREQ_BITS - LO_W;
   localparam int PL_W = POS_BITS + LO_W;
   localparam int PH_W = POS_BITS + HI_W;

   // ---------------- configuration ----------------
   logic [PAIRS_W-1:0] active_pairs_ff;
   logic [AMP_W-1:0]   amp_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_pairs_ff <= ACTIVE_PAIRS_RST;
         amp_scale_ff    <= AMP_SCALE_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ACTIVE_PAIRS: active_pairs_ff <= csr_wdata[PAIRS_W-1:0];
            CSR_AMP_SCALE:    amp_scale_ff    <= csr_wdata[AMP_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- issue control ----------------
   logic          adv;
   logic          accept;
   logic          busy_ff,  busy_in;
   logic [CW-1:0] idx_ff,   idx_in;
   logic [CW-1:0] pairs_ff, pairs_in;
   logic [POS_BITS-1:0] pos_ff;
   logic [CW-1:0] pairs_eff;
   logic          issue_last;

   // pos_ff feeds stage two, so a new word is only taken on an advancing edge
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = busy_ff || !adv;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (active_pairs_ff > PAIRS_W'(MAX_PAIRS))
         pairs_eff = CW'(MAX_PAIRS);
      else
         pairs_eff = CW'(active_pairs_ff);
   end

   assign issue_last = (idx_ff == pairs_ff - CW'(1));

   always_comb begin
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      pairs_in = pairs_ff;
      if (accept && req_action == ACT_COMPUTE) begin
         pairs_in = pairs_eff;
         idx_in   = '0;
         busy_in  = (pairs_eff != '0);
      end else if (busy_ff && adv) begin
         idx_in = idx_ff + CW'(1);
         if (issue_last)
            busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         idx_ff   <= '0;
         pairs_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
         pairs_ff <= pairs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_action == ACT_COMPUTE)
         pos_ff <= req_position;
   end

   // ---------------- frequency table ----------------
   logic [FREQ_BITS-1:0] freq_mem [MAX_PAIRS];
   logic [FREQ_BITS-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (accept && req_action == ACT_LOAD &&
          (PAIRS_W'(req_entry_index) < PAIRS_W'(MAX_PAIRS)))
         freq_mem[req_entry_index[AW-1:0]] <= req_entry_freq;
   end

   always_ff @(posedge clock) begin
      if (adv)
         rd_ff <= freq_mem[idx_ff[AW-1:0]];
   end

   // stage 1 tag travels with the read data
   logic       v1_ff, l1_ff;
   logic [5:0] p1_ff;

   always_ff @(posedge clock) begin
      if (reset)
         v1_ff <= 1'b0;
      else if (adv)
         v1_ff <= busy_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         l1_ff <= issue_last;
         p1_ff <= 6'(idx_ff);
      end
   end

   // ---------------- phase product, split in two halves ----------------
   logic            v2_ff, l2_ff;
   logic [5:0]      p2_ff;
   logic [PL_W-1:0] plo_ff;
   logic [PH_W-1:0] phi_prod_ff;

   always_ff @(posedge clock) begin
      if (reset)
         v2_ff <= 1'b0;
      else if (adv)
         v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         l2_ff       <= l1_ff;
         p2_ff       <= p1_ff;
         plo_ff      <= PL_W'(pos_ff) * PL_W'(rd_ff[LO_W-1:0]);
         phi_prod_ff <= PH_W'(pos_ff) * PH_W'(rd_ff[FREQ_BITS-1:LO_W]);
      end
   end

   logic [FREQ_BITS-1:0] phase;
   logic [31:0]          phi;

   assign phase = FREQ_BITS'(plo_ff) + (FREQ_BITS'(phi_prod_ff) << LO_W);

   generate
      if (FREQ_BITS >= 32) begin : g_trunc
         assign phi = phase[FREQ_BITS-1 -: 32];
      end else begin : g_shift
         assign phi = {phase, (32 - FREQ_BITS)'(0)};
      end
   endgenerate

   // ---------------- polynomial pipeline ----------------
   poly_type s3_ff, s4_ff, s5_ff, s6_ff, s7_ff, s8_ff;
   poly_type s3_in, s4_in, s5_in, s6_in, s7_in, s8_in;

   always_comb begin
      s3_in       = '0;
      s3_in.valid = v2_ff;
      s3_in.last  = l2_ff;
      s3_in.pair  = p2_ff;
      s3_in.quad  = phi[31:30];
      s3_in.xs    = {1'b0, phi[29:0]};
      s3_in.xc    = Q30_ONE - {1'b0, phi[29:0]};

      s4_in     = s3_ff;
      s4_in.x2s = q30_mul(s3_ff.xs, s3_ff.xs);
      s4_in.x2c = q30_mul(s3_ff.xc, s3_ff.xc);

      s5_in    = s4_ff;
      s5_in.ts = horner_step(s4_ff.x2s, C9, C7);
      s5_in.tc = horner_step(s4_ff.x2c, C9, C7);

      s6_in    = s5_ff;
      s6_in.ts = horner_step(s5_ff.x2s, s5_ff.ts, C5);
      s6_in.tc = horner_step(s5_ff.x2c, s5_ff.tc, C5);

      s7_in    = s6_ff;
      s7_in.ts = horner_step(s6_ff.x2s, s6_ff.ts, C3);
      s7_in.tc = horner_step(s6_ff.x2c, s6_ff.tc, C3);

      s8_in    = s7_ff;
      s8_in.ts = horner_step(s7_ff.x2s, s7_ff.ts, C1);
      s8_in.tc = horner_step(s7_ff.x2c, s7_ff.tc, C1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ff.valid <= 1'b0;
         s4_ff.valid <= 1'b0;
         s5_ff.valid <= 1'b0;
         s6_ff.valid <= 1'b0;
         s7_ff.valid <= 1'b0;
         s8_ff.valid <= 1'b0;
      end else if (adv) begin
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
         s7_ff <= s7_in;
         s8_ff <= s8_in;
      end
   end

   // final multiply: f = x * t
   logic        v9_ff, l9_ff;
   logic [5:0]  p9_ff;
   logic [1:0]  q9_ff;
   logic [30:0] fx_ff, fc_ff;

   always_ff @(posedge clock) begin
      if (reset)
         v9_ff <= 1'b0;
      else if (adv)
         v9_ff <= s8_ff.valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         l9_ff <= s8_ff.last;
         p9_ff <= s8_ff.pair;
         q9_ff <= s8_ff.quad;
         fx_ff <= q30_mul(s8_ff.xs, s8_ff.ts);
         fc_ff <= q30_mul(s8_ff.xc, s8_ff.tc);
      end
   end

   // quadrant fold and amplitude multiply
   logic [30:0] sm, cm;
   logic        sneg, cneg;

   always_comb begin
      case (q9_ff)
         2'd0: begin sm = fx_ff; sneg = 1'b0; cm = fc_ff; cneg = 1'b0; end
         2'd1: begin sm = fc_ff; sneg = 1'b0; cm = fx_ff; cneg = 1'b1; end
         2'd2: begin sm = fx_ff; sneg = 1'b1; cm = fc_ff; cneg = 1'b1; end
         default: begin sm = fc_ff; sneg = 1'b1; cm = fx_ff; cneg = 1'b0; end
      endcase
   end

   logic        v10_ff, l10_ff, sneg10_ff, cneg10_ff;
   logic [5:0]  p10_ff;
   logic [46:0] sprod_ff, cprod_ff;

   always_ff @(posedge clock) begin
      if (reset)
         v10_ff <= 1'b0;
      else if (adv)
         v10_ff <= v9_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         l10_ff    <= l9_ff;
         p10_ff    <= p9_ff;
         sneg10_ff <= sneg;
         cneg10_ff <= cneg;
         sprod_ff  <= 47'(sm) * 47'(amp_scale_ff);
         cprod_ff  <= 47'(cm) * 47'(amp_scale_ff);
      end
   end

   // round, sign and saturate
   function automatic logic [OUT_W-1:0] round_sat(input logic [46:0] prod,
                                                  input logic neg);
      logic [47:0] r;
      logic [18:0] v;
      r = 48'(prod) + 48'(1 << 28);
      v = r[47:29];
      if (neg) begin
         if (v > NEG_SAT)
            v = NEG_SAT;
         return OUT_W'(19'd0 - v);
      end
      if (v > POS_SAT)
         v = POS_SAT;
      return v[OUT_W-1:0];
   endfunction

   // ---------------- output register ----------------
   logic                    rsp_valid_ff;
   logic [IDX_W-1:0]        rsp_pair_ff;
   logic [OUT_W-1:0]        rsp_cos_ff, rsp_sin_ff;
   logic                    rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (adv)
         rsp_valid_ff <= v10_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_pair_ff <= p10_ff;
         rsp_last_ff <= l10_ff;
         rsp_cos_ff  <= round_sat(cprod_ff, cneg10_ff);
         rsp_sin_ff  <= round_sat(sprod_ff, sneg10_ff);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pair_index = rsp_pair_ff;
   assign rsp_cosine     = $signed(rsp_cos_ff);
   assign rsp_sine       = $signed(rsp_sin_ff);
   assign rsp_last       = rsp_last_ff;

   // ---------------- assertions ----------------
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff < pairs_ff))
      else $error("issue index beyond run length");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && adv && issue_last) |=> !busy_ff)
      else $error("run did not end after last issue");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      (!adv && !$past(reset)) |=> ($stable(s5_ff.valid) && $stable(v10_ff)))
      else $error("pipeline moved while stalled");

   a_last_tag: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && adv) |=> (v1_ff && (l1_ff == $past(issue_last))))
      else $error("stage one tag mismatch");

endmodule
